@@ hw/rtl/qrm_pkg.sv @@
// Shared types and constants for the quaternion to rotation matrix block.
// No dependencies; used by qrm_div and quaternion_to_rotation_matrix.
package qrm_pkg;

  localparam int IN_W   = 16;
  localparam int FRAC   = 14;
  localparam int OUT_W  = FRAC + 2;
  localparam int PROD_W = 2 * IN_W;
  localparam int MAG_W  = 2 * IN_W + 1;
  localparam int NUM_W  = 2 * IN_W + 2;
  localparam int NUM_ENTRIES = 9;

  localparam logic signed [OUT_W-1:0] ONE_FIXED = OUT_W'(1) << FRAC;

  typedef struct packed {
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
    logic signed [IN_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
    logic                    degenerate;
  } rot_t;

endpackage

@@ hw/rtl/quaternion_to_rotation_matrix.sv @@
// Quaternion to 3x3 rotation matrix, top level. Depends on qrm_pkg and qrm_div.
//
// Input channel in_valid/in_stall/in_data carries one quaternion (x, y, z, w) of
// signed 16-bit components at any common scale. Output channel
// out_valid/out_stall/out_data carries the nine entries in Q1.14 (16384 = 1.0)
// plus a degenerate flag; an all-zero quaternion gives the identity matrix
// with the flag set.
// Registered stages, in order: the ten products, the pairwise sums, the norm
// and the numerators, the sign and magnitude split, then a 17-stage divider
// per entry (integer bit, 15 fraction bits, rounding).
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the divider pipeline that takes one quotient bit per stage.
// The whole pipeline advances together. When the receiver stalls with a
// result waiting, every stage holds and in_stall rises in the same cycle, so
// nothing is dropped or repeated. Reset clears all valid bits; data registers
// are not reset.
module quaternion_to_rotation_matrix (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  qrm_pkg::quat_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output qrm_pkg::rot_t  out_data
);
  import qrm_pkg::*;

  localparam int DIV_LAT = FRAC + 3;

  logic en;
  assign en       = ~out_valid | ~out_stall;
  assign in_stall = ~en;

  // Stage a: products.
  logic signed [PROD_W-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;
  logic vld_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= in_data.quat_x * in_data.quat_x;
      yy_r <= in_data.quat_y * in_data.quat_y;
      zz_r <= in_data.quat_z * in_data.quat_z;
      ww_r <= in_data.quat_w * in_data.quat_w;
      xy_r <= in_data.quat_x * in_data.quat_y;
      xz_r <= in_data.quat_x * in_data.quat_z;
      yz_r <= in_data.quat_y * in_data.quat_z;
      xw_r <= in_data.quat_x * in_data.quat_w;
      yw_r <= in_data.quat_y * in_data.quat_w;
      zw_r <= in_data.quat_z * in_data.quat_w;
    end
  end

  // Stage b: pairwise sums, so that each later stage needs a single add.
  logic signed [NUM_W-1:0] exx, eyy, ezz, eww, exy, exz, eyz, exw, eyw, ezw;
  logic signed [NUM_W-1:0] sxw_r, syz_r, syw_r, sxz_r, szw_r, sxy_r;
  logic signed [NUM_W-1:0] h01_r, h02_r, h10_r, h12_r, h20_r, h21_r;
  logic vld_b_r;

  assign exx = NUM_W'(xx_r);
  assign eyy = NUM_W'(yy_r);
  assign ezz = NUM_W'(zz_r);
  assign eww = NUM_W'(ww_r);
  assign exy = NUM_W'(xy_r);
  assign exz = NUM_W'(xz_r);
  assign eyz = NUM_W'(yz_r);
  assign exw = NUM_W'(xw_r);
  assign eyw = NUM_W'(yw_r);
  assign ezw = NUM_W'(zw_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sxw_r <= exx + eww;
      syz_r <= eyy + ezz;
      syw_r <= eyy + eww;
      sxz_r <= exx + ezz;
      szw_r <= ezz + eww;
      sxy_r <= exx + eyy;
      h01_r <= exy + ezw;
      h02_r <= exz - eyw;
      h10_r <= exy - ezw;
      h12_r <= eyz + exw;
      h20_r <= exz + eyw;
      h21_r <= eyz - exw;
    end
  end

  // Stage c: norm and the nine numerators. A diagonal entry n - 2(a + b)
  // equals the sum of the other two squares minus a and b.
  logic signed [NUM_W-1:0] n_s;
  logic signed [NUM_W-1:0] num_s [NUM_ENTRIES];
  logic signed [NUM_W-1:0] num_r [NUM_ENTRIES];
  logic signed [NUM_W-1:0] nrm_r;
  logic                    deg_c_r;
  logic                    vld_c_r;

  assign n_s = sxw_r + syz_r;

  assign num_s[0] = sxw_r - syz_r;
  assign num_s[1] = h01_r <<< 1;
  assign num_s[2] = h02_r <<< 1;
  assign num_s[3] = h10_r <<< 1;
  assign num_s[4] = syw_r - sxz_r;
  assign num_s[5] = h12_r <<< 1;
  assign num_s[6] = h20_r <<< 1;
  assign num_s[7] = h21_r <<< 1;
  assign num_s[8] = szw_r - sxy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        num_r[k] <= num_s[k];
      end
      nrm_r   <= n_s;
      deg_c_r <= (n_s == '0);
    end
  end

  // Stage d: numerators split into magnitude and sign.
  logic signed [NUM_W-1:0] neg_num [NUM_ENTRIES];
  logic [MAG_W-1:0] mag_r [NUM_ENTRIES];
  logic             neg_r [NUM_ENTRIES];
  logic [MAG_W-1:0] n_r;
  logic             deg_d_r;
  logic             vld_d_r;

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_neg
    assign neg_num[k] = -num_r[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        mag_r[k] <= num_r[k][NUM_W-1] ? neg_num[k][MAG_W-1:0] : num_r[k][MAG_W-1:0];
        neg_r[k] <= num_r[k][NUM_W-1];
      end
      n_r     <= nrm_r[MAG_W-1:0];
      deg_d_r <= deg_c_r;
    end
  end

  // Dividers, one per entry.
  logic signed [OUT_W-1:0] quo [NUM_ENTRIES];

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_div
    qrm_div u_div (
      .clk     (clk),
      .en      (en),
      .num_mag (mag_r[k]),
      .num_neg (neg_r[k]),
      .den     (n_r),
      .quo     (quo[k])
    );
  end

  // Valid and degenerate flags travel alongside the divider stages.
  logic vld_p_r [DIV_LAT];
  logic deg_p_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vld_p_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_a_r    <= in_valid;
      vld_b_r    <= vld_a_r;
      vld_c_r    <= vld_b_r;
      vld_d_r    <= vld_c_r;
      vld_p_r[0] <= vld_d_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vld_p_r[i] <= vld_p_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_p_r[0] <= deg_d_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        deg_p_r[i] <= deg_p_r[i-1];
      end
    end
  end

  logic deg;
  assign deg       = deg_p_r[DIV_LAT-1];
  assign out_valid = vld_p_r[DIV_LAT-1];

  // A zero norm leaves the divider outputs meaningless; the identity replaces them.
  assign out_data.m00        = deg ? ONE_FIXED : quo[0];
  assign out_data.m01        = deg ? '0 : quo[1];
  assign out_data.m02        = deg ? '0 : quo[2];
  assign out_data.m10        = deg ? '0 : quo[3];
  assign out_data.m11        = deg ? ONE_FIXED : quo[4];
  assign out_data.m12        = deg ? '0 : quo[5];
  assign out_data.m20        = deg ? '0 : quo[6];
  assign out_data.m21        = deg ? '0 : quo[7];
  assign out_data.m22        = deg ? ONE_FIXED : quo[8];
  assign out_data.degenerate = deg;

endmodule

@@ hw/rtl/qrm_div.sv @@
// Pipelined restoring divider for one matrix entry: |num| / den in Q1.FRAC,
// rounded to nearest with ties away from zero. Depends on qrm_pkg.
module qrm_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [qrm_pkg::MAG_W-1:0]        num_mag,
  input  logic                             num_neg,
  input  logic [qrm_pkg::MAG_W-1:0]        den,
  output logic signed [qrm_pkg::OUT_W-1:0] quo
);
  import qrm_pkg::*;

  localparam int STEPS = FRAC + 1;
  localparam int QW    = FRAC + 2;
  localparam int REM_W = MAG_W + 1;

  logic [REM_W-1:0] rem_r [0:STEPS];
  logic [MAG_W-1:0] den_r [0:STEPS];
  logic [QW-1:0]    q_r   [0:STEPS];
  logic             neg_r [0:STEPS];
  logic signed [OUT_W-1:0] quo_r;

  // Integer bit: the numerator never exceeds the norm, so one subtract suffices.
  always_ff @(posedge clk) begin
    if (en) begin
      if (num_mag >= den) begin
        rem_r[0] <= {1'b0, num_mag - den};
        q_r[0]   <= QW'(1);
      end else begin
        rem_r[0] <= {1'b0, num_mag};
        q_r[0]   <= '0;
      end
      den_r[0] <= den;
      neg_r[0] <= num_neg;
    end
  end

  for (genvar s = 1; s <= STEPS; s++) begin : g_step
    logic [REM_W-1:0] dbl;
    logic             ge;
    assign dbl = {rem_r[s-1][REM_W-2:0], 1'b0};
    assign ge  = dbl >= {1'b0, den_r[s-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? dbl - {1'b0, den_r[s-1]} : dbl;
        q_r[s]   <= {q_r[s-1][QW-2:0], ge};
        den_r[s] <= den_r[s-1];
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  logic [QW:0]      rnd_sum;
  logic [QW-1:0]    mag;
  logic [OUT_W-1:0] mag_sat;

  assign rnd_sum = {1'b0, q_r[STEPS]} + (QW+1)'(1);
  assign mag     = rnd_sum[QW:1];
  assign mag_sat = (mag > QW'(ONE_FIXED)) ? ONE_FIXED : OUT_W'(mag);

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[STEPS] ? -mag_sat : mag_sat;
    end
  end

  assign quo = quo_r;

endmodule
